// File: sv/mst_pkg.sv
// Shared types and constants for the min segment tree threshold query block.
// Word layouts of the request, result and configuration channels.
// No dependencies.
package mst_pkg;

    // Operation codes carried in the request word
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Value that initialize puts in leaves at or above leaves_in_use and below LEAVES
    localparam int unsigned BIG_VALUE = 32'd10000000;

    // Reset value of the leaves_in_use register
    localparam logic [6:0] LEAVES_IN_USE_RST = 7'd64;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         leaf_slot;
        logic signed [23:0] delta;
        logic [23:0]        threshold;
    } t_req;

    typedef struct packed {
        logic [5:0] leaf_number;
        logic       matched;
        logic       last_of_run;
    } t_rsp;

    typedef struct packed {
        logic [6:0] leaves_in_use;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ADD_LEAF,
        S_ADD_UP,
        S_QUERY,
        S_QEND
    } t_state;

endpackage

// File: sv/mst_stream_if.sv
// Valid/ready stream interface, one word per handshake.
// The word type is a parameter; used with the word types of mst_pkg.
interface mst_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/min_segment_tree_threshold_query.sv
// Min segment tree over LEAVES counters with initialize, add and threshold query.
// Depends on mst_pkg (word types, codes, state enum) and mst_stream_if.
//
//  channel  dir  word                                         handshake
//  i_in     in   operation, leaf_slot, delta, threshold       valid/ready
//  o_out    out  leaf_number, matched, last_of_run            valid/ready
//  i_cfg    in   leaves_in_use                                valid/ready
//
// One request at a time. The tree lives in one memory of 2*P words
// (P = LEAVES rounded up to a power of two), one read and one write a cycle.
// Add: one read-modify-write per tree level.
// Initialize: one node written per cycle. After reset the same
// sweep runs with i_in.ready low; i_cfg is always ready.
// Query: one memory read per tree node visited; it pauses while the
// result register is full.
module min_segment_tree_threshold_query #(
    parameter int LEAVES     = 64,
    parameter int VALUE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mst_stream_if.sink            i_in,
    mst_stream_if.source          o_out,
    mst_stream_if.sink            i_cfg
);
    import mst_pkg::*;

    localparam int LOG   = $clog2(LEAVES);
    localparam int P     = 1 << LOG;
    localparam int NB    = LOG + 1;
    localparam int DEPTH = 2 * P;
    localparam int TZW   = $clog2(NB + 1);

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] BIG_V     = VALUE_BITS'(BIG_VALUE);
    localparam logic [6:0]            LEAVES7   = 7'(LEAVES);
    localparam logic [NB-1:0]         ROOT      = NB'(1);

    // Node value after initialize: set by the node's leftmost leaf
    function automatic logic [VALUE_BITS-1:0] init_val(input logic [NB-1:0] k,
                                                        input logic [6:0]    used);
        logic [NB-1:0]  sh;
        logic [LOG-1:0] lf;
        logic [6:0]     lf7;
        lf = '0;
        for (int d = 0; d <= LOG; d++) begin
            sh = k << d;
            if ((k >> (LOG - d)) == ROOT) lf = sh[LOG-1:0];
        end
        lf7 = 7'(lf);
        if (lf7 < used) return '0;
        else if (lf7 < LEAVES7) return BIG_V;
        else return VALUE_MAX;
    endfunction

    // Tree memory
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;
    logic [NB-1:0]         mem_raddr;
    logic                  mem_we;
    logic [NB-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;

    // Control and datapath registers
    t_state                r_state, n_state;
    logic [NB-1:0]         r_node, n_node;
    logic [VALUE_BITS-1:0] r_cur, n_cur;
    logic [23:0]           r_thr;
    logic signed [23:0]    r_delta;
    logic                  r_pend_v;
    logic [5:0]            r_pend_leaf;
    logic                  r_boot;
    logic [6:0]            r_liu;
    logic                  r_out_v;
    t_rsp                  r_out;

    // Shared decode
    logic                  in_acc;
    logic                  out_free;
    logic [6:0]            used;
    logic                  slot_ok;
    logic [NB-1:0]         slot_node;
    logic [23:0]           mag;
    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS-1:0] leaf_new;
    logic [NB-1:0]         parent;
    logic [VALUE_BITS-1:0] pmin;
    logic                  q_le;
    logic                  q_leaf;
    logic                  q_hit;
    logic                  q_desc;
    logic [NB:0]           k1;
    logic [TZW-1:0]        tz;
    logic [NB:0]           succ;
    logic                  q_done;
    logic                  q_stall;
    logic                  q_push;
    logic                  e_push;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_v || o_out.ready;

    always_comb begin
        // leaves_in_use above LEAVES acts as LEAVES; the boot sweep uses the reset value
        used      = r_boot ? ((LEAVES_IN_USE_RST > LEAVES7) ? LEAVES7 : LEAVES_IN_USE_RST)
                           : ((r_liu > LEAVES7) ? LEAVES7 : r_liu);
        slot_ok   = {1'b0, i_in.data.leaf_slot} < LEAVES7;
        slot_node = {1'b1, i_in.data.leaf_slot[LOG-1:0]};

        // Saturating leaf update
        mag = 24'd0 - r_delta;
        sum = {1'b0, r_rdata} + (VALUE_BITS + 1)'(r_delta[22:0]);
        if (r_delta[23]) begin
            leaf_new = (VALUE_BITS'(mag) >= r_rdata) ? '0 : r_rdata - VALUE_BITS'(mag);
        end else begin
            leaf_new = sum[VALUE_BITS] ? VALUE_MAX : sum[VALUE_BITS-1:0];
        end

        // Ancestor recompute
        parent = r_node >> 1;
        pmin   = (r_rdata < r_cur) ? r_rdata : r_cur;

        // Query walk: descend on a hit, else move to the next subtree in order
        q_le   = r_rdata <= VALUE_BITS'(r_thr);
        q_leaf = r_node[NB-1];
        q_hit  = q_le && q_leaf && ({1'b0, 6'(r_node[LOG-1:0])} < LEAVES7);
        q_desc = q_le && !q_leaf;
        k1     = {1'b0, r_node} + (NB + 1)'(1);
        tz     = '0;
        for (int i = NB; i >= 0; i--) begin
            if (k1[TZW'(i)]) tz = TZW'(i);
        end
        succ    = k1 >> tz;
        q_done  = !q_desc && (succ == (NB + 1)'(1));
        q_stall = q_hit && r_pend_v && !out_free;
        q_push  = (r_state == S_QUERY) && q_hit && r_pend_v && out_free;
        e_push  = (r_state == S_QEND) && out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.data.operation)
                        OP_INIT:  n_state = S_INIT;
                        OP_ADD:   n_state = slot_ok ? S_ADD_LEAF : S_IDLE;
                        OP_QUERY: n_state = S_QUERY;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT:     if (r_node == ROOT) n_state = S_IDLE;
            S_ADD_LEAF: n_state = S_ADD_UP;
            S_ADD_UP:   if (parent == ROOT) n_state = S_IDLE;
            S_QUERY:    if (!q_stall && q_done) n_state = S_QEND;
            S_QEND:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory port and walk control
    always_comb begin
        mem_raddr = r_node;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = r_cur;
        n_node    = r_node;
        n_cur     = r_cur;
        unique case (r_state)
            S_IDLE: begin
                case (i_in.data.operation)
                    OP_ADD: begin
                        mem_raddr = slot_node;
                        n_node    = slot_node;
                    end
                    OP_INIT: begin
                        mem_raddr = ROOT;
                        n_node    = NB'(DEPTH - 1);
                    end
                    default: begin
                        mem_raddr = ROOT;
                        n_node    = ROOT;
                    end
                endcase
                if (!in_acc) n_node = r_node;
            end
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = init_val(r_node, used);
                n_node    = r_node - ROOT;
            end
            S_ADD_LEAF: begin
                mem_we    = 1'b1;
                mem_wdata = leaf_new;
                n_cur     = leaf_new;
                mem_raddr = r_node ^ ROOT;
            end
            S_ADD_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = pmin;
                n_cur     = pmin;
                mem_raddr = parent ^ ROOT;
                n_node    = parent;
            end
            S_QUERY: begin
                if (q_stall) begin
                    mem_raddr = r_node;
                end else if (q_desc) begin
                    mem_raddr = r_node << 1;
                end else begin
                    mem_raddr = succ[NB-1:0];
                end
                n_node = mem_raddr;
            end
            S_QEND:  mem_raddr = r_node;
            default: mem_raddr = r_node;
        endcase
    end

    // Tree memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_node   <= NB'(DEPTH - 1);
            r_boot   <= 1'b1;
            r_liu    <= LEAVES_IN_USE_RST;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            if (r_state == S_INIT && r_node == ROOT) r_boot <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) r_liu <= i_cfg.data.leaves_in_use;

            // Pending hit is held back until we know whether it is the last
            if (r_state == S_QUERY && q_hit && !q_stall) r_pend_v <= 1'b1;
            else if (e_push) r_pend_v <= 1'b0;

            if (q_push || e_push) r_out_v <= 1'b1;
            else if (o_out.ready) r_out_v <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (in_acc) begin
            r_thr   <= i_in.data.threshold;
            r_delta <= i_in.data.delta;
        end
        if (r_state == S_QUERY && q_hit && !q_stall) r_pend_leaf <= 6'(r_node[LOG-1:0]);
        if (q_push) begin
            r_out.leaf_number <= r_pend_leaf;
            r_out.matched     <= 1'b1;
            r_out.last_of_run <= 1'b0;
        end else if (e_push) begin
            r_out.leaf_number <= r_pend_v ? r_pend_leaf : 6'd0;
            r_out.matched     <= r_pend_v;
            r_out.last_of_run <= 1'b1;
        end
    end

endmodule

// File: sv/mst_checker.sv
// Port-level checks for min_segment_tree_threshold_query, with its bind.
// Depends on mst_pkg for the result word type.
module mst_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input mst_pkg::t_rsp i_out_data
);
    import mst_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // An unmatched result word is the closing word of its run
    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.matched |-> i_out_data.last_of_run)
        else $error("unmatched word not marked last");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.matched |-> i_out_data.leaf_number == 6'd0)
        else $error("unmatched word carries a leaf number");

    // Within a run, leaves come out in strictly ascending order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last_of_run |=>
            !i_out_valid ||
            (i_out_data.matched && i_out_data.leaf_number > $past(i_out_data.leaf_number)))
        else $error("run not ascending");

endmodule

bind min_segment_tree_threshold_query mst_checker u_mst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
